@@ rtl/dbee_pkg.sv @@
`timescale 1ns / 1ps
package dbee_pkg;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_NUM1,
		PH_SP1,
		PH_SP2,
		PH_NUM2,
		PH_ZERO,
		PH_FIRST,
		PH_BOTH
	} phase_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [1:0] {
		RK_ZERO,
		RK_FIRST,
		RK_CALC
	} res_kind_t;

	typedef enum logic [1:0] {
		EX_IDLE,
		EX_DIV,
		EX_WB
	} exec_state_t;

	typedef struct packed {
		res_kind_t kind;
		op_t       op;
		logic      sat;
	} cmd_ctl_t;

	localparam int OUT_WIDTH = 32;

	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_opchar(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
	endfunction

	function automatic op_t op_of(input logic [7:0] c);
		op_t o;
		unique case (c)
			CH_MINUS: o = OP_SUB;
			CH_STAR:  o = OP_MUL;
			CH_SLASH: o = OP_DIV;
			default:  o = OP_ADD;
		endcase
		return o;
	endfunction

endpackage

@@ rtl/dbee_parser.sv @@
`timescale 1ns / 1ps
module dbee_parser
	import dbee_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic                   mode,
	input  logic [7:0]             character,
	output logic                   push,
	output cmd_ctl_t               cmd_ctl,
	output logic [VALUE_WIDTH-2:0] cmd_a,
	output logic [VALUE_WIDTH-2:0] cmd_b
);

	localparam int OW = VALUE_WIDTH - 1;
	localparam int AW = OW + 4;
	localparam logic [OW-1:0] OMAX = {OW{1'b1}};

	phase_t        phase_q, phase_d;
	op_t           op_q, op_d;
	logic [OW-1:0] first_q, second_q;
	logic          sat_q;

	logic          is_char;
	logic          dig;
	logic [OW-1:0] acc_in;
	logic [AW-1:0] acc_wide;
	logic          acc_ovf;
	logic [OW-1:0] acc_res;
	logic          wr_first, wr_second;

	assign is_char = take && !mode;
	assign dig     = is_dig(character);

	always_comb begin
		phase_d = phase_q;
		op_d    = op_q;
		if (is_char) begin
			unique case (phase_q)
				PH_LEAD: begin
					if (dig) phase_d = PH_NUM1;
					else if (!is_ws(character)) phase_d = PH_ZERO;
				end
				PH_NUM1: begin
					if (!dig) begin
						if (is_ws(character)) begin
							phase_d = PH_SP1;
						end else if (is_opchar(character)) begin
							phase_d = PH_SP2;
							op_d    = op_of(character);
						end else begin
							phase_d = PH_FIRST;
						end
					end
				end
				PH_SP1: begin
					if (!is_ws(character)) begin
						if (is_opchar(character)) begin
							phase_d = PH_SP2;
							op_d    = op_of(character);
						end else begin
							phase_d = PH_FIRST;
						end
					end
				end
				PH_SP2: begin
					if (dig) phase_d = PH_NUM2;
					else if (!is_ws(character)) phase_d = (op_q == OP_MUL) ? PH_ZERO : PH_FIRST;
				end
				PH_NUM2: begin
					if (!dig) phase_d = PH_BOTH;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		wr_first  = is_char && dig && ((phase_q == PH_LEAD) || (phase_q == PH_NUM1));
		wr_second = is_char && dig && ((phase_q == PH_SP2) || (phase_q == PH_NUM2));
		unique case (phase_q)
			PH_NUM1: acc_in = first_q;
			PH_NUM2: acc_in = second_q;
			default: acc_in = '0;
		endcase
		acc_wide = (AW'(acc_in) << 3) + (AW'(acc_in) << 1) + AW'(character - CH_ZERO);
		acc_ovf  = acc_wide > AW'(OMAX);
		acc_res  = acc_ovf ? OMAX : acc_wide[OW-1:0];

		push         = take && mode;
		cmd_a        = first_q;
		cmd_b        = second_q;
		cmd_ctl.op   = op_q;
		cmd_ctl.sat  = sat_q;
		unique case (phase_q)
			PH_NUM1, PH_SP1, PH_FIRST: cmd_ctl.kind = RK_FIRST;
			PH_SP2:                    cmd_ctl.kind = (op_q == OP_MUL) ? RK_ZERO : RK_FIRST;
			PH_NUM2, PH_BOTH:          cmd_ctl.kind = RK_CALC;
			default:                   cmd_ctl.kind = RK_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			op_q     <= OP_ADD;
			first_q  <= '0;
			second_q <= '0;
			sat_q    <= 1'b0;
		end else if (push) begin
			phase_q  <= PH_LEAD;
			op_q     <= OP_ADD;
			first_q  <= '0;
			second_q <= '0;
			sat_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			op_q    <= op_d;
			if (wr_first) first_q <= acc_res;
			if (wr_second) second_q <= acc_res;
			if ((wr_first || wr_second) && acc_ovf) sat_q <= 1'b1;
		end
	end

endmodule

@@ rtl/dbee_queue.sv @@
`timescale 1ns / 1ps
module dbee_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wptr_q, rptr_q;
	logic [1:0]       count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign pop_data  = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/dbee_exec.sv @@
`timescale 1ns / 1ps
module dbee_exec
	import dbee_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	input  cmd_ctl_t               cmd_ctl,
	input  logic [VALUE_WIDTH-2:0] cmd_a,
	input  logic [VALUE_WIDTH-2:0] cmd_b,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_WIDTH-1:0]   out_value,
	output logic                   out_dz,
	output logic                   out_ovf
);

	localparam int OW = VALUE_WIDTH - 1;
	localparam int MW = (VALUE_WIDTH < OUT_WIDTH) ? VALUE_WIDTH : OUT_WIDTH;
	localparam int CW = $clog2(OW);

	exec_state_t state_q, state_d;

	logic                 valid_q;
	logic [OUT_WIDTH-1:0] value_q;
	logic                 dz_q, ovf_q;

	logic [OW-1:0] dvd_q, rem_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          dsat_q;

	logic          slot_free;
	logic          b_zero;
	logic          is_div;
	logic          load_out;
	logic          start_div;
	logic [MW-1:0] am, bm, prod, res;
	logic          res_dz, res_ovf;
	logic [OW:0]   trial;
	logic          ge;

	assign slot_free = !valid_q || out_ready;
	assign b_zero    = cmd_b == '0;
	assign is_div    = (cmd_ctl.kind == RK_CALC) && (cmd_ctl.op == OP_DIV) && !b_zero;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EX_IDLE: if (cmd_valid && is_div) state_d = EX_DIV;
			EX_DIV:  if (cnt_q == '0) state_d = EX_WB;
			EX_WB:   if (slot_free) state_d = EX_IDLE;
			default: state_d = EX_IDLE;
		endcase
	end

	always_comb begin
		start_div = (state_q == EX_IDLE) && cmd_valid && is_div;
		pop       = start_div || ((state_q == EX_IDLE) && cmd_valid && slot_free);
		load_out  = ((state_q == EX_IDLE) && cmd_valid && !is_div && slot_free)
			|| ((state_q == EX_WB) && slot_free);

		am   = MW'(cmd_a);
		bm   = MW'(cmd_b);
		prod = am * bm;

		res_dz  = 1'b0;
		res_ovf = cmd_ctl.sat;
		case (cmd_ctl.kind)
			RK_FIRST: res = am;
			RK_CALC: begin
				case (cmd_ctl.op)
					OP_ADD:  res = am + bm;
					OP_SUB:  res = am - bm;
					OP_MUL:  res = prod;
					default: begin
						res    = '0;
						res_dz = 1'b1;
					end
				endcase
			end
			default: res = '0;
		endcase
		if (state_q == EX_WB) begin
			res     = MW'(dvd_q);
			res_dz  = 1'b0;
			res_ovf = dsat_q;
		end

		trial = {rem_q, dvd_q[OW-1]};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			value_q <= OUT_WIDTH'(res);
			dz_q    <= res_dz;
			ovf_q   <= res_ovf;
		end
		if (start_div) begin
			dvd_q  <= cmd_a;
			dvs_q  <= cmd_b;
			rem_q  <= '0;
			dsat_q <= cmd_ctl.sat;
			cnt_q  <= CW'(OW - 1);
		end else if (state_q == EX_DIV) begin
			rem_q <= ge ? OW'(trial - {1'b0, dvs_q}) : trial[OW-1:0];
			dvd_q <= {dvd_q[OW-2:0], ge};
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign out_value = value_q;
	assign out_dz    = dz_q;
	assign out_ovf   = ovf_q;

endmodule

@@ rtl/decimal_binary_expr_evaluator_core.sv @@
`timescale 1ns / 1ps
// Decimal expression evaluator: "number op number" over a byte stream.
// Input stream s_*: one transfer per character (s_tuser = 0, byte in s_tdata),
// then one transfer with s_tuser = 1 closing the string. Characters are taken
// one per cycle while s_tready is high; only a closing transfer yields a result.
// Output stream m_*: one transfer per closed string, value in m_tdata,
// divide-by-zero and operand-saturation flags in m_tuser.
// Results of an empty, single-number, add, subtract or multiply expression go
// straight from the queue into the output register; a division result comes
// from the one-bit-per-cycle restoring divider.
// A two-entry command queue sits between parser and executor, so the parser
// keeps taking characters while a division runs or m_tready is low; s_tready
// drops only when the queue is full, and the input then waits.
// A result held in the output register stays until m_tready is seen.
// Reset clears the parser to its leading-whitespace state and empties
// queue and output register; no clearing pass is needed.
module decimal_binary_expr_evaluator_core
	import dbee_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] character
	input  logic        s_tuser,  // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] value
	output logic [1:0]  m_tuser   // [0] divide_by_zero, [1] number_overflow
);

	localparam int OW = VALUE_WIDTH - 1;
	localparam int CTLW = $bits(cmd_ctl_t);
	localparam int QW = CTLW + 2 * OW;

	logic          take;
	logic          push;
	cmd_ctl_t      p_ctl, e_ctl;
	logic [OW-1:0] p_a, p_b, e_a, e_b;
	logic          q_full, q_valid, pop;
	logic [QW-1:0] q_out;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	dbee_parser #(.VALUE_WIDTH(VALUE_WIDTH)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.mode      (s_tuser),
		.character (s_tdata),
		.push      (push),
		.cmd_ctl   (p_ctl),
		.cmd_a     (p_a),
		.cmd_b     (p_b)
	);

	dbee_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({p_a, p_b, p_ctl}),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.pop_data  (q_out)
	);

	assign e_ctl = cmd_ctl_t'(q_out[CTLW-1:0]);
	assign e_b   = q_out[CTLW+OW-1:CTLW];
	assign e_a   = q_out[QW-1:CTLW+OW];

	dbee_exec #(.VALUE_WIDTH(VALUE_WIDTH)) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ctl   (e_ctl),
		.cmd_a     (e_a),
		.cmd_b     (e_b),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (m_tdata),
		.out_dz    (m_tuser[0]),
		.out_ovf   (m_tuser[1])
	);

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import dbee_pkg::*;

	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [31:0] OPERAND_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [31:0] value;
		logic        dz;
		logic        ovf;
	} expr_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] character
	logic        s_tuser = 1'b0; // [0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [31:0] value
	logic [1:0]  m_tuser;        // [0] divide_by_zero, [1] number_overflow

	expr_result_t pending_results[$];
	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int cycles = 0;
	int unsigned hold_off_len = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;

	phase_t     ph = PH_LEAD;
	logic [30:0] lhs = '0;
	logic [30:0] rhs = '0;
	op_t        opr = OP_ADD;
	logic       sat = 1'b0;

	decimal_binary_expr_evaluator_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit ws_byte(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit digit_byte(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic [30:0] add_digit(input logic [30:0] acc, input logic [7:0] c);
		logic [31:0] d;
		logic [31:0] next;
		d = {24'd0, c} - {24'd0, CH_ZERO};
		if ({1'b0, acc} > (OPERAND_MAX - d) / 10) begin
			sat = 1'b1;
			return OPERAND_MAX[30:0];
		end
		next = {1'b0, acc} * 32'd10 + d;
		return next[30:0];
	endfunction

	function automatic void take_operator(input logic [7:0] c);
		ph = PH_SP2;
		case (c)
			CH_PLUS: opr = OP_ADD;
			CH_MINUS: opr = OP_SUB;
			CH_STAR: opr = OP_MUL;
			CH_SLASH: opr = OP_DIV;
			default: ph = PH_FIRST;
		endcase
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		case (ph)
			PH_LEAD: begin
				if (digit_byte(c)) begin
					lhs = add_digit('0, c);
					ph = PH_NUM1;
				end else if (!ws_byte(c))
					ph = PH_ZERO;
			end
			PH_NUM1: begin
				if (digit_byte(c))
					lhs = add_digit(lhs, c);
				else if (ws_byte(c))
					ph = PH_SP1;
				else
					take_operator(c);
			end
			PH_SP1: begin
				if (!ws_byte(c))
					take_operator(c);
			end
			PH_SP2: begin
				if (digit_byte(c)) begin
					rhs = add_digit('0, c);
					ph = PH_NUM2;
				end else if (!ws_byte(c))
					ph = (opr == OP_MUL) ? PH_ZERO : PH_FIRST;
			end
			PH_NUM2: begin
				if (digit_byte(c))
					rhs = add_digit(rhs, c);
				else
					ph = PH_BOTH;
			end
			default: ;
		endcase
	endfunction

	function automatic expr_result_t evaluate_expr();
		expr_result_t r;
		logic [31:0] a;
		logic [31:0] b;
		a = {1'b0, lhs};
		b = {1'b0, rhs};
		r = '0;
		case (ph)
			PH_NUM1, PH_SP1, PH_FIRST: r.value = a;
			PH_SP2: r.value = (opr == OP_MUL) ? 32'd0 : a;
			PH_NUM2, PH_BOTH: begin
				case (opr)
					OP_ADD: r.value = a + b;
					OP_SUB: r.value = a - b;
					OP_MUL: r.value = a * b;
					default: begin
						if (b == 0)
							r.dz = 1'b1;
						else
							r.value = a / b;
					end
				endcase
			end
			default: r.value = '0;
		endcase
		r.ovf = sat;
		ph = PH_LEAD;
		lhs = '0;
		rhs = '0;
		opr = OP_ADD;
		sat = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	task automatic send_item(input logic mode, input logic [7:0] c);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (mode)
			pending_results.insert(pending_results.size(), evaluate_expr());
		else
			parse_char(c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(1'b0, s[i]);
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] pick_ws();
		logic [7:0] c;
		c = 8'($urandom_range(8, 13));
		return (c == 8) ? CH_SPACE : c;
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(0, 3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	task automatic send_number();
		int len;
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			len = $urandom_range(1, 3);
		else if (r < 85)
			len = $urandom_range(4, 9);
		else
			len = $urandom_range(10, 12);
		repeat (len) send_item(1'b0, CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic send_random_expr(input int junk_pct);
		repeat ($urandom_range(0, 2)) send_item(1'b0, pick_ws());
		if ($urandom_range(0, 99) < junk_pct)
			send_item(1'b0, 8'($urandom_range(0, 255)));
		send_number();
		repeat ($urandom_range(0, 2)) send_item(1'b0, pick_ws());
		if ($urandom_range(0, 99) < 88)
			send_item(1'b0, pick_op());
		else if ($urandom_range(0, 1) == 0)
			send_item(1'b0, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 2)) send_item(1'b0, pick_ws());
		if ($urandom_range(0, 99) < 85)
			send_number();
		repeat ($urandom_range(0, 2)) send_item(1'b0, 8'($urandom_range(0, 255)));
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_directed();
		send_text("");
		send_text(" \t");
		send_item(1'b0, 8'hFF);
		send_item(1'b1, 8'h00);
		send_text("5");
		send_text("9+");
		send_text("6*");
		send_text("8/0");
		send_text("7-9");
		send_text("3*4");
		send_text("9/2");
	endtask

	task automatic test_random_exprs();
		while (items_sent < 800)
			send_random_expr(10);
	endtask

	task automatic test_noise();
		while (items_sent < 900) begin
			if ($urandom_range(0, 1) == 0)
				send_random_expr(100);
			else
				send_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
		end
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_backpressure();
		hold_off_len = 300;
		repeat (10) send_random_expr(0);
	endtask

	task automatic test_streaming();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		while (items_sent < 1150)
			send_random_expr(10);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			if (hold_off_len > 0) begin
				m_tready <= 1'b0;
				repeat (hold_off_len) @(posedge clk);
				hold_off_len = 0;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 32'd0);
			end else begin
				expr_result_t want;
				want = pending_results.pop_front();
				results_checked++;
				if (m_tdata !== want.value)
					report_mismatch("value", m_tdata, want.value);
				if (m_tuser[0] !== want.dz)
					report_mismatch("divide_by_zero", {31'd0, m_tuser[0]}, {31'd0, want.dz});
				if (m_tuser[1] !== want.ovf)
					report_mismatch("number_overflow", {31'd0, m_tuser[1]}, {31'd0, want.ovf});
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_exprs();
		test_noise();
		test_backpressure();
		test_streaming();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d transfers (expressions, noise, long output stall, streaming),",
			items_sent);
		$display("checked %0d results with %0d mismatches.", results_checked, errors);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/dbee_pkg.sv
rtl/dbee_parser.sv
rtl/dbee_queue.sv
rtl/dbee_exec.sv
rtl/decimal_binary_expr_evaluator_core.sv
sim/tb.sv
